/* src/prime_field_alu_256_defines.svh */
// Assertion macros shared by the field unit.
`ifndef PRIME_FIELD_ALU_256_DEFINES_SVH
`define PRIME_FIELD_ALU_256_DEFINES_SVH
`ifndef SYNTHESIS
`define PFA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PFA_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define PFA_ASSERT(label, clk, rst_n, prop, msg)
`define PFA_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

/* src/pfa_pkg.sv */
package pfa_pkg;
  localparam int unsigned FieldBitsDef = 256;
  localparam int unsigned LimbBits = 64;

  typedef enum logic [2:0] {
    KindAdd = 3'd0, KindSub = 3'd1, KindMul = 3'd2, KindNeg = 3'd3,
    KindInv = 3'd4, KindDiv = 3'd5, KindRed = 3'd6, KindRsv = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    CfgLimb0 = 2'd0, CfgLimb1 = 2'd1, CfgLimb2 = 2'd2, CfgLimb3 = 2'd3
  } cfg_idx_e;

  // Shared-unit command: one bit step of a double-and-add loop
  typedef struct packed {
    logic go;
    logic add_en;
  } step_t;
endpackage

/* src/prime_field_alu_256.sv */
// Channel  | Direction | Ports
// ---------+-----------+------------------------------------------------
// request  | in        | start_i, busy_o, kind_i, a_limb0_i..3, b_limb0_i..3
// result   | out       | done_o, r_limb0_o..3, error_o
// config   | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i
// Every bit step is a double then a conditional add in one shared add/compare unit.
// A request first reduces both operands, W steps each; add, subtract, negate and
// reduce then go to the result state, and multiply adds W steps. An inverse adds W
// squarings and up to W multiplies of W steps each; the worst case, a divide, adds
// one more multiply of W steps after the inverse.
// Reset clears the sequencer; done_o pulses for one cycle and cannot be stalled.
module prime_field_alu_256 #(
  parameter int unsigned FIELD_BITS = pfa_pkg::FieldBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [63:0] a_limb0_i,
  input  logic [63:0] a_limb1_i,
  input  logic [63:0] a_limb2_i,
  input  logic [63:0] a_limb3_i,
  input  logic [63:0] b_limb0_i,
  input  logic [63:0] b_limb1_i,
  input  logic [63:0] b_limb2_i,
  input  logic [63:0] b_limb3_i,
  output logic        done_o,
  output logic [63:0] r_limb0_o,
  output logic [63:0] r_limb1_o,
  output logic [63:0] r_limb2_o,
  output logic [63:0] r_limb3_o,
  output logic        error_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);
  import pfa_pkg::*;
  `include "prime_field_alu_256_defines.svh"

  localparam int unsigned W  = FIELD_BITS;
  localparam int unsigned CW = $clog2(W);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StRedA  = 9'b000000010,
    StRedB  = 9'b000000100,
    StDisp  = 9'b000001000,
    StMulAB = 9'b000010000,
    StSq    = 9'b000100000,
    StMulX  = 9'b001000000,
    StFin   = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e        state_q, state_d;
  logic [255:0]  prime_q;
  logic [W-1:0]  p, a_q, b_q, x_q, e_q, acc_q, mul_q, mult_q, addend;
  logic [W-1:0]  ra_q, rb_q, res_q, step_acc;
  logic [CW-1:0] bit_q, ebit_q;
  logic [2:0]    kind_q;
  logic          err_q, step_done;
  step_t         cmd;
  logic [W:0]    sub_ab, add_ab;

  assign p = prime_q[W-1:0];

  // Hold the prime limbs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prime_q <= '0;
    else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgLimb0: prime_q[63:0]    <= cfg_wdata_i;
        CfgLimb1: prime_q[127:64]  <= cfg_wdata_i;
        CfgLimb2: prime_q[191:128] <= cfg_wdata_i;
        CfgLimb3: prime_q[255:192] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Select the operand bit and addend for the current loop
  logic bit_sel;
  always_comb begin
    bit_sel = 1'b0;
    addend  = '0;
    unique case (state_q)
      StRedA:  begin bit_sel = a_q[bit_q];  addend = W'(1); end
      StRedB:  begin bit_sel = b_q[bit_q];  addend = W'(1); end
      StMulAB: begin bit_sel = mult_q[bit_q]; addend = mul_q; end
      StSq:    begin bit_sel = acc_q[bit_q]; addend = acc_q; end
      StMulX:  begin bit_sel = x_q[bit_q];  addend = acc_q; end
      default: ;
    endcase
    cmd.go     = (state_q == StRedA) || (state_q == StRedB) || (state_q == StMulAB)
              || (state_q == StSq) || (state_q == StMulX);
    cmd.add_en = bit_sel;
  end

  pfa_step #(.W(W)) u_step (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .p_i(p),
    .acc_i(res_q), .addend_i(addend), .done_o(step_done), .acc_o(step_acc)
  );

  assign sub_ab = {1'b0, ra_q} - {1'b0, rb_q};
  assign add_ab = {1'b0, ra_q} + {1'b0, rb_q};

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  logic last_bit;
  assign last_bit = (bit_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (start_i) state_d = StRedA;
      StRedA:  if (step_done && last_bit) state_d = StRedB;
      StRedB:  if (step_done && last_bit) state_d = StDisp;
      StDisp:  begin
        if (err_q || p == '0) state_d = StOut;
        else begin
          case (kind_e'(kind_q))
            KindMul: state_d = StMulAB;
            KindInv: state_d = (ra_q == '0) ? StOut : StSq;
            KindDiv: state_d = (rb_q == '0) ? StOut : StSq;
            default: state_d = StOut;
          endcase
        end
      end
      StMulAB: if (step_done && last_bit) state_d = StOut;
      StSq:    if (step_done && last_bit) state_d = e_q[ebit_q] ? StMulX : StFin;
      StMulX:  if (step_done && last_bit) state_d = StFin;
      StFin:   begin
        if (ebit_q != '0) state_d = StSq;
        else if (kind_e'(kind_q) == KindDiv) state_d = StMulAB;
        else state_d = StOut;
      end
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (start_i) begin
        kind_q <= kind_i;
        a_q <= W'({a_limb3_i, a_limb2_i, a_limb1_i, a_limb0_i});
        b_q <= W'({b_limb3_i, b_limb2_i, b_limb1_i, b_limb0_i});
        res_q <= '0; bit_q <= CW'(W-1); err_q <= 1'b0;
      end
      StRedA: if (step_done) begin
        res_q <= last_bit ? '0 : step_acc;
        bit_q <= last_bit ? CW'(W-1) : bit_q - 1'b1;
        if (last_bit) ra_q <= step_acc;
      end
      StRedB: if (step_done) begin
        res_q <= step_acc; bit_q <= bit_q - 1'b1;
        if (last_bit) rb_q <= step_acc;
      end
      StDisp: begin
        bit_q <= CW'(W-1);
        e_q <= p - W'(2); ebit_q <= CW'(W-1);
        mul_q <= ra_q; mult_q <= rb_q;
        x_q <= (kind_e'(kind_q) == KindInv) ? ra_q : rb_q;
        acc_q <= (W == 1) ? '0 : ((p == W'(1)) ? '0 : W'(1));
        err_q <= (p == '0) || ((kind_e'(kind_q) == KindInv) && (ra_q == '0))
                 || ((kind_e'(kind_q) == KindDiv) && (rb_q == '0));
        if (p == '0) res_q <= '0;
        else begin
          case (kind_e'(kind_q))
            KindAdd: res_q <= (add_ab[W] || add_ab[W-1:0] >= p)
                              ? W'(add_ab - {1'b0, p}) : add_ab[W-1:0];
            KindSub: res_q <= sub_ab[W] ? W'(sub_ab[W-1:0] + p) : sub_ab[W-1:0];
            KindNeg: res_q <= (ra_q == '0) ? '0 : W'(p - ra_q);
            KindMul: res_q <= '0;
            KindInv: res_q <= '0;
            KindDiv: res_q <= '0;
            default: res_q <= ra_q;
          endcase
        end
      end
      StMulAB: if (step_done) begin
        res_q <= step_acc; bit_q <= bit_q - 1'b1;
      end
      StSq: if (step_done) begin
        res_q <= last_bit ? '0 : step_acc;
        bit_q <= last_bit ? CW'(W-1) : bit_q - 1'b1;
        if (last_bit) acc_q <= step_acc;
      end
      StMulX: if (step_done) begin
        res_q <= step_acc; bit_q <= bit_q - 1'b1;
        if (last_bit) acc_q <= step_acc;
      end
      StFin: begin
        bit_q <= CW'(W-1);
        if (ebit_q != '0) begin
          ebit_q <= ebit_q - 1'b1;
          res_q  <= '0;
        end else begin
          res_q  <= (kind_e'(kind_q) == KindDiv) ? '0 : acc_q;
          mul_q  <= ra_q; mult_q <= acc_q;
        end
      end
      default: ;
    endcase
  end

  assign busy_o  = (state_q != StIdle);
  assign done_o  = (state_q == StOut);
  assign error_o = err_q;
  logic [255:0] r_full;
  assign r_full    = err_q ? '0 : 256'(res_q);
  assign r_limb0_o = r_full[63:0];
  assign r_limb1_o = r_full[127:64];
  assign r_limb2_o = r_full[191:128];
  assign r_limb3_o = r_full[255:192];

  `PFA_ASSERT(a_done_after_busy, clk_i, rst_ni, done_o |=> !busy_o, "done must return to idle")
  `PFA_ASSERT(a_err_zero, clk_i, rst_ni, (done_o && error_o) |-> (r_full == '0), "error result not zero")
  `PFA_ASSERT_NEVER(a_onehot, clk_i, rst_ni, !$onehot(state_q), "state not one-hot")
endmodule

/* src/pfa_step.sv */
// Shared modular step unit: acc = 2*acc (+ addend) mod p, one bit per call:
// a registered double, then a conditional add.
module pfa_step #(
  parameter int unsigned W = pfa_pkg::FieldBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pfa_pkg::step_t cmd_i,
  input  logic [W-1:0] p_i,
  input  logic [W-1:0] acc_i,
  input  logic [W-1:0] addend_i,
  output logic         done_o,
  output logic [W-1:0] acc_o
);
  import pfa_pkg::*;

  logic         phase_q, phase_d;
  logic         add_q, add_d;
  logic [W-1:0] acc_q, acc_d;
  logic [W:0]   sum;
  logic [W:0]   diff;

  // Pick operands by phase and add with a trial subtract of p
  always_comb begin
    if (!phase_q) sum = {1'b0, acc_i} + {1'b0, acc_i};
    else          sum = {1'b0, acc_q} + (add_q ? {1'b0, addend_i} : '0);
    diff = sum - {1'b0, p_i};
  end

  always_comb begin
    phase_d = phase_q;
    add_d   = add_q;
    acc_d   = acc_q;
    if (cmd_i.go && !phase_q) begin
      phase_d = 1'b1;
      add_d   = cmd_i.add_en;
      acc_d   = diff[W] ? sum[W-1:0] : diff[W-1:0];
    end else if (phase_q) begin
      phase_d = 1'b0;
      acc_d   = diff[W] ? sum[W-1:0] : diff[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      add_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      add_q   <= add_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign done_o = phase_q;
  assign acc_o  = acc_d;
endmodule
